### src/vptg_pkg.sv
// Package for the vibration pulse train generator.
// Holds the opcode and status codes, limits, and the state and result types.
// No dependencies.
`default_nettype none

package vptg_pkg;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_PULSE   = 2'd1,
        OP_PATTERN = 2'd2,
        OP_STOP    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NREADY = 2'd1,
        ST_BADARG = 2'd2
    } t_status;

    typedef enum logic {
        REG_ENABLE     = 1'b0,
        REG_DEFAULT_MS = 1'b1
    } t_reg_index;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [9:0]  RESET_DEFAULT_MS = 10'd50;
    localparam logic [15:0] MAX_PULSE_MS     = 16'd1000;
    localparam logic [15:0] MAX_PATTERN_ON   = 16'd500;
    localparam logic [15:0] MAX_GAP_MS       = 16'd1000;
    localparam logic [7:0]  MAX_COUNT        = 8'd10;

    typedef struct packed {
        logic [3:0] pulses_remaining;
        logic [9:0] phase_timer;
        logic [9:0] pulse_length;
        logic [9:0] gap_length;
        logic       motor_level;
    } t_state;

    typedef struct packed {
        logic       motor_drive;
        logic [1:0] status;
        logic       busy_res;
        logic [3:0] pulses_left;
    } t_result;

endpackage

`default_nettype wire

### src/vptg_cmd_if.sv
// Command channel of the vibration pulse train generator.
// Carries valid, ready and one command beat. No dependencies.
`default_nettype none

interface vptg_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  pulse_count;
    logic [15:0] on_time_ms;
    logic [15:0] gap_time_ms;

    modport source (
        output valid, opcode, pulse_count, on_time_ms, gap_time_ms,
        input  ready
    );
    modport sink (
        input  valid, opcode, pulse_count, on_time_ms, gap_time_ms,
        output ready
    );
endinterface

`default_nettype wire

### src/vptg_res_if.sv
// Result channel of the vibration pulse train generator.
// Carries valid, ready and one result beat. No dependencies.
`default_nettype none

interface vptg_res_if;
    logic       valid;
    logic       ready;
    logic       motor_drive;
    logic [1:0] status;
    logic       busy_res;
    logic [3:0] pulses_left;

    modport source (
        output valid, motor_drive, status, busy_res, pulses_left,
        input  ready
    );
    modport sink (
        input  valid, motor_drive, status, busy_res, pulses_left,
        output ready
    );
endinterface

`default_nettype wire

### src/vibration_pulse_train_generator_top.sv
// Top level of the vibration pulse train generator.
// Depends on vptg_pkg, vptg_cmd_if, vptg_res_if and vptg_step.
//
//   Channel   Direction  Beat contents
//   i_cmd     in         opcode, pulse_count, on_time_ms, gap_time_ms
//   o_res     out        motor_drive, status, busy_res, pulses_left
//   i_cfg_*   in         register index and write data, no handshake
//
// Each command beat is processed combinationally; its result appears in the
// result register on the following cycle. One beat can be taken per cycle
// whenever the result register is empty or being drained.
// Sync active-low reset clears state and enable; default_ms to 50.
`default_nettype none

module vibration_pulse_train_generator_top (
    input  var logic                              i_clk,
    input  var logic                              i_rst_n,
    input  var logic                              i_cfg_we,
    input  var logic [vptg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  var logic [vptg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    vptg_cmd_if.sink                              i_cmd,
    vptg_res_if.source                            o_res
);

    vptg_pkg::t_state  r_state;
    vptg_pkg::t_state  n_state;
    vptg_pkg::t_result r_res;
    vptg_pkg::t_result n_res;
    logic              r_valid;
    logic              r_enable;
    logic [9:0]        r_default_ms;
    logic              s_accept;

    assign i_cmd.ready = !r_valid || o_res.ready;
    assign s_accept    = i_cmd.valid && i_cmd.ready;

    vptg_step u_step (
        .i_state       (r_state),
        .i_enable      (r_enable),
        .i_default_ms  (r_default_ms),
        .i_opcode      (i_cmd.opcode),
        .i_pulse_count (i_cmd.pulse_count),
        .i_on_time_ms  (i_cmd.on_time_ms),
        .i_gap_time_ms (i_cmd.gap_time_ms),
        .o_state       (n_state),
        .o_result      (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_default_ms <= vptg_pkg::RESET_DEFAULT_MS;
        end else if (i_cfg_we) begin
            unique case (vptg_pkg::t_reg_index'(i_cfg_idx))
                vptg_pkg::REG_ENABLE:     r_enable     <= i_cfg_data[0];
                vptg_pkg::REG_DEFAULT_MS: r_default_ms <= i_cfg_data;
                default:                  r_enable     <= r_enable;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_state <= n_state;
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.motor_drive = r_res.motor_drive;
    assign o_res.status      = r_res.status;
    assign o_res.busy_res    = r_res.busy_res;
    assign o_res.pulses_left = r_res.pulses_left;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pulses_remaining <= 4'd10)
        else $error("pulse count above ten");

    a_motor_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.motor_level |-> (r_state.pulses_remaining != 4'd0))
        else $error("motor on with no sequence");

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (i_cmd.opcode == vptg_pkg::OP_STOP)) |=>
        (!r_state.motor_level && (r_state.pulses_remaining == 4'd0)))
        else $error("stop left sequence running");

    a_disabled_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !r_enable && ((i_cmd.opcode == vptg_pkg::OP_PULSE) ||
        (i_cmd.opcode == vptg_pkg::OP_PATTERN))) |=>
        ($stable(r_state) && (r_res.status == vptg_pkg::ST_NREADY)))
        else $error("disabled command changed state");

endmodule

`default_nettype wire

### src/vptg_step.sv
// Next-state and result logic for one command beat.
// Depends on vptg_pkg for codes, limits and the state and result types.
`default_nettype none

module vptg_step (
    input  var vptg_pkg::t_state  i_state,
    input  var logic              i_enable,
    input  var logic [9:0]        i_default_ms,
    input  var logic [1:0]        i_opcode,
    input  var logic [7:0]        i_pulse_count,
    input  var logic [15:0]       i_on_time_ms,
    input  var logic [15:0]       i_gap_time_ms,
    output vptg_pkg::t_state      o_state,
    output vptg_pkg::t_result     o_result
);

    vptg_pkg::t_state  s_cur;
    vptg_pkg::t_state  s_nxt;
    vptg_pkg::t_status s_status;
    vptg_pkg::t_opcode s_op;
    logic [15:0]       s_len_raw;
    logic [9:0]        s_len;
    logic [3:0]        s_left;
    logic              s_pattern_bad;

    assign s_cur = i_state;
    assign s_op  = vptg_pkg::t_opcode'(i_opcode);

    assign s_len_raw = (i_on_time_ms == 16'd0) ? {6'd0, i_default_ms} : i_on_time_ms;
    assign s_len     = (s_len_raw > vptg_pkg::MAX_PULSE_MS) ?
                       vptg_pkg::MAX_PULSE_MS[9:0] : s_len_raw[9:0];

    assign s_pattern_bad = (i_pulse_count == 8'd0) ||
                           (i_pulse_count > vptg_pkg::MAX_COUNT) ||
                           (i_on_time_ms == 16'd0) ||
                           (i_on_time_ms > vptg_pkg::MAX_PATTERN_ON) ||
                           (i_gap_time_ms > vptg_pkg::MAX_GAP_MS);

    assign s_left = s_cur.pulses_remaining - 4'd1;

    always_comb begin
        s_nxt    = s_cur;
        s_status = vptg_pkg::ST_OK;
        unique case (s_op)
            vptg_pkg::OP_TICK: begin
                if (s_cur.pulses_remaining != 4'd0) begin
                    if (s_cur.phase_timer[9:1] == 9'd0) begin
                        if (s_cur.motor_level) begin
                            if (s_left != 4'd0) begin
                                s_nxt.motor_level      = 1'b0;
                                s_nxt.pulses_remaining = s_left;
                                s_nxt.phase_timer      = s_cur.gap_length;
                            end else begin
                                s_nxt = '0;
                            end
                        end else begin
                            s_nxt.motor_level = 1'b1;
                            s_nxt.phase_timer = s_cur.pulse_length;
                        end
                    end else begin
                        s_nxt.phase_timer = s_cur.phase_timer - 10'd1;
                    end
                end
            end
            vptg_pkg::OP_STOP: begin
                s_nxt = '0;
            end
            vptg_pkg::OP_PULSE: begin
                if (!i_enable) begin
                    s_status = vptg_pkg::ST_NREADY;
                end else begin
                    s_nxt.pulses_remaining = 4'd1;
                    s_nxt.pulse_length     = s_len;
                    s_nxt.gap_length       = 10'd0;
                    s_nxt.motor_level      = 1'b1;
                    s_nxt.phase_timer      = s_len;
                end
            end
            vptg_pkg::OP_PATTERN: begin
                if (!i_enable) begin
                    s_status = vptg_pkg::ST_NREADY;
                end else if (s_pattern_bad) begin
                    s_status = vptg_pkg::ST_BADARG;
                end else begin
                    s_nxt.pulses_remaining = i_pulse_count[3:0];
                    s_nxt.pulse_length     = i_on_time_ms[9:0];
                    s_nxt.gap_length       = i_gap_time_ms[9:0];
                    s_nxt.motor_level      = 1'b1;
                    s_nxt.phase_timer      = i_on_time_ms[9:0];
                end
            end
            default: begin
                s_nxt = s_cur;
            end
        endcase
    end

    assign o_state              = s_nxt;
    assign o_result.motor_drive = s_nxt.motor_level;
    assign o_result.status      = s_status;
    assign o_result.busy_res    = (s_nxt.pulses_remaining != 4'd0);
    assign o_result.pulses_left = s_nxt.pulses_remaining;

endmodule

`default_nettype wire

### tb/sv/vibration_pulse_train_generator_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the vibration pulse train generator top level.
// Drives directed and random command beats and checks every result beat against a table value or a prediction.
// Depends on vptg_pkg, vptg_cmd_if, vptg_res_if and vibration_pulse_train_generator_top.

module vibration_pulse_train_generator_top_tb;

    typedef struct packed {
        vptg_pkg::t_opcode op;
        logic [7:0]        count;
        logic [15:0]       on_ms;
        logic [15:0]       gap_ms;
    } t_cmd_beat;

    typedef struct packed {
        t_cmd_beat         cmd;
        logic              typed;
        vptg_pkg::t_result want;
    } t_stim_row;

    localparam int unsigned IDLE_LIMIT      = 2000;
    localparam int unsigned DRAIN_CYCLES    = 4;
    localparam int unsigned DISABLED_ROWS   = 4;
    localparam int unsigned STIM_ROWS       = 25;
    localparam int unsigned PHASES          = 7;
    localparam int unsigned ITEMS_PER_PHASE = 65;

    localparam vptg_pkg::t_result IDLE_RESULT   = '0;
    localparam vptg_pkg::t_result NREADY_RESULT = '{1'b0, vptg_pkg::ST_NREADY, 1'b0, 4'd0};
    localparam vptg_pkg::t_result BADARG_RESULT = '{1'b0, vptg_pkg::ST_BADARG, 1'b0, 4'd0};
    localparam vptg_pkg::t_result ONE_PULSE     = '{1'b1, vptg_pkg::ST_OK, 1'b1, 4'd1};
    localparam vptg_pkg::t_result TEN_PULSES    = '{1'b1, vptg_pkg::ST_OK, 1'b1, 4'd10};
    localparam vptg_pkg::t_result THREE_PULSES  = '{1'b1, vptg_pkg::ST_OK, 1'b1, 4'd3};

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [vptg_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [vptg_pkg::CFG_DATA_W-1:0] cfg_data;

    vptg_cmd_if cmd_bus ();
    vptg_res_if res_bus ();

    vibration_pulse_train_generator_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd_bus),
        .o_res      (res_bus)
    );

    vptg_pkg::t_state  motor_state;
    logic              cfg_enable;
    logic [9:0]        cfg_default_ms;
    vptg_pkg::t_result expected_results [$];
    int unsigned       mismatch_count = 0;
    int unsigned       idle_cycles = 0;
    bit                throttle_on;

    t_stim_row stim_rows [STIM_ROWS] = '{
        '{'{vptg_pkg::OP_TICK,    8'd0,   16'd0,    16'd0},    1'b1, IDLE_RESULT},
        '{'{vptg_pkg::OP_PULSE,   8'd0,   16'd100,  16'd0},    1'b1, NREADY_RESULT},
        '{'{vptg_pkg::OP_PATTERN, 8'd3,   16'd100,  16'd100},  1'b1, NREADY_RESULT},
        '{'{vptg_pkg::OP_STOP,    8'd255, 16'hFFFF, 16'hFFFF}, 1'b1, IDLE_RESULT},
        '{'{vptg_pkg::OP_PATTERN, 8'd0,   16'd100,  16'd100},  1'b1, BADARG_RESULT},
        '{'{vptg_pkg::OP_PATTERN, 8'd11,  16'd100,  16'd100},  1'b1, BADARG_RESULT},
        '{'{vptg_pkg::OP_PATTERN, 8'd3,   16'd0,    16'd100},  1'b1, BADARG_RESULT},
        '{'{vptg_pkg::OP_PATTERN, 8'd3,   16'd501,  16'd100},  1'b1, BADARG_RESULT},
        '{'{vptg_pkg::OP_PATTERN, 8'd3,   16'd100,  16'd1001}, 1'b1, BADARG_RESULT},
        '{'{vptg_pkg::OP_PATTERN, 8'd255, 16'hFFFF, 16'hFFFF}, 1'b1, BADARG_RESULT},
        '{'{vptg_pkg::OP_PATTERN, 8'd10,  16'd500,  16'd1000}, 1'b1, TEN_PULSES},
        '{'{vptg_pkg::OP_PATTERN, 8'd0,   16'd0,    16'd0},    1'b0, IDLE_RESULT},
        '{'{vptg_pkg::OP_TICK,    8'd0,   16'd0,    16'd0},    1'b0, IDLE_RESULT},
        '{'{vptg_pkg::OP_STOP,    8'd0,   16'd0,    16'd0},    1'b1, IDLE_RESULT},
        '{'{vptg_pkg::OP_PULSE,   8'd0,   16'd0,    16'd0},    1'b1, ONE_PULSE},
        '{'{vptg_pkg::OP_TICK,    8'd255, 16'hFFFF, 16'hFFFF}, 1'b0, IDLE_RESULT},
        '{'{vptg_pkg::OP_PULSE,   8'd0,   16'hFFFF, 16'd0},    1'b1, ONE_PULSE},
        '{'{vptg_pkg::OP_TICK,    8'd0,   16'd0,    16'd0},    1'b0, IDLE_RESULT},
        '{'{vptg_pkg::OP_PATTERN, 8'd1,   16'd1,    16'd0},    1'b1, ONE_PULSE},
        '{'{vptg_pkg::OP_TICK,    8'd0,   16'd0,    16'd0},    1'b1, IDLE_RESULT},
        '{'{vptg_pkg::OP_PATTERN, 8'd3,   16'd1,    16'd0},    1'b1, THREE_PULSES},
        '{'{vptg_pkg::OP_TICK,    8'd0,   16'd0,    16'd0},    1'b0, IDLE_RESULT},
        '{'{vptg_pkg::OP_TICK,    8'd0,   16'd0,    16'd0},    1'b0, IDLE_RESULT},
        '{'{vptg_pkg::OP_TICK,    8'd0,   16'd0,    16'd0},    1'b0, IDLE_RESULT},
        '{'{vptg_pkg::OP_TICK,    8'd0,   16'd0,    16'd0},    1'b0, IDLE_RESULT}
    };

    bit         phase_enable  [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    logic [9:0] phase_default [PHASES] = '{10'd50, 10'd0, 10'd1023, 10'd1000, 10'd1,
                                           10'd1000, 10'd50};

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic void load_sequence(input logic [3:0] count, input logic [9:0] on_len,
                                          input logic [9:0] gap_len);
        motor_state.pulses_remaining = count;
        motor_state.pulse_length     = on_len;
        motor_state.gap_length       = gap_len;
        motor_state.motor_level      = 1'b1;
        motor_state.phase_timer      = on_len;
    endfunction

    function automatic vptg_pkg::t_result predict_motor(input t_cmd_beat c);
        vptg_pkg::t_result r;
        vptg_pkg::t_status st;
        logic [15:0]       len;
        st = vptg_pkg::ST_OK;
        case (c.op)
            vptg_pkg::OP_TICK: begin
                if (motor_state.pulses_remaining != 4'd0) begin
                    if (motor_state.phase_timer > 10'd1) begin
                        motor_state.phase_timer--;
                    end else if (motor_state.motor_level) begin
                        motor_state.motor_level = 1'b0;
                        motor_state.pulses_remaining--;
                        if (motor_state.pulses_remaining != 4'd0) begin
                            motor_state.phase_timer = motor_state.gap_length;
                        end else begin
                            motor_state = '0;
                        end
                    end else begin
                        motor_state.motor_level = 1'b1;
                        motor_state.phase_timer = motor_state.pulse_length;
                    end
                end
            end
            vptg_pkg::OP_STOP: begin
                motor_state = '0;
            end
            default: begin
                if (!cfg_enable) begin
                    st = vptg_pkg::ST_NREADY;
                end else if (c.op == vptg_pkg::OP_PULSE) begin
                    len = (c.on_ms == 16'd0) ? {6'd0, cfg_default_ms} : c.on_ms;
                    if (len > vptg_pkg::MAX_PULSE_MS) len = vptg_pkg::MAX_PULSE_MS;
                    load_sequence(4'd1, len[9:0], 10'd0);
                end else if (c.count == 8'd0 || c.count > vptg_pkg::MAX_COUNT ||
                             c.on_ms == 16'd0 || c.on_ms > vptg_pkg::MAX_PATTERN_ON ||
                             c.gap_ms > vptg_pkg::MAX_GAP_MS) begin
                    st = vptg_pkg::ST_BADARG;
                end else begin
                    load_sequence(c.count[3:0], c.on_ms[9:0], c.gap_ms[9:0]);
                end
            end
        endcase
        r.motor_drive = motor_state.motor_level;
        r.status      = st;
        r.busy_res    = (motor_state.pulses_remaining != 4'd0);
        r.pulses_left = motor_state.pulses_remaining;
        return r;
    endfunction

    function automatic t_cmd_beat random_cmd();
        t_cmd_beat   c;
        int unsigned pick;
        c.op     = vptg_pkg::OP_TICK;
        c.count  = 8'($urandom);
        c.on_ms  = 16'($urandom);
        c.gap_ms = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 55) begin
            c.op = vptg_pkg::OP_TICK;
        end else if (pick < 72) begin
            c.op     = vptg_pkg::OP_PATTERN;
            c.count  = ($urandom_range(9) == 0) ? 8'($urandom_range(1, 10))
                                                : 8'($urandom_range(1, 4));
            c.on_ms  = ($urandom_range(9) == 0) ? 16'($urandom_range(1, 500))
                                                : 16'($urandom_range(1, 4));
            c.gap_ms = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 1000))
                                                : 16'($urandom_range(0, 3));
        end else if (pick < 82) begin
            c.op    = vptg_pkg::OP_PULSE;
            c.on_ms = 16'($urandom_range(0, 5));
        end else if (pick < 85) begin
            c.op = vptg_pkg::OP_PULSE;
        end else if (pick < 90) begin
            c.op = vptg_pkg::OP_STOP;
        end else begin
            c.op = vptg_pkg::OP_PATTERN;
        end
        return c;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned pick;
        pick = $urandom_range(99);
        if (!throttle_on || pick < 55) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic send_cmd(input t_cmd_beat c, input logic typed,
                            input vptg_pkg::t_result want);
        int unsigned       gap;
        vptg_pkg::t_result predicted;
        gap = pick_gap();
        if (gap != 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.opcode      <= c.op;
        cmd_bus.pulse_count <= c.count;
        cmd_bus.on_time_ms  <= c.on_ms;
        cmd_bus.gap_time_ms <= c.gap_ms;
        do @(posedge i_clk); while (!cmd_bus.ready);
        predicted = predict_motor(c);
        expected_results.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        cmd_bus.valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input vptg_pkg::t_reg_index idx,
                             input logic [vptg_pkg::CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            vptg_pkg::REG_ENABLE:     cfg_enable = data[0];
            vptg_pkg::REG_DEFAULT_MS: cfg_default_ms = data;
            default:                  ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned run_len;
        logic        level;
        run_len = 0;
        level   = 1'b0;
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run_len == 0) begin
                if (!throttle_on || $urandom_range(99) < 60) begin
                    level   = 1'b1;
                    run_len = $urandom_range(1, 20);
                end else if ($urandom_range(99) < 85) begin
                    level   = 1'b0;
                    run_len = $urandom_range(1, 3);
                end else begin
                    level   = 1'b0;
                    run_len = $urandom_range(10, 40);
                end
            end
            res_bus.ready <= level;
            run_len--;
        end
    end

    always @(posedge i_clk) begin
        vptg_pkg::t_result got;
        vptg_pkg::t_result want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got = '{res_bus.motor_drive, res_bus.status, res_bus.busy_res, res_bus.pulses_left};
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with nothing expected", got, 0);
            end else begin
                want = expected_results.pop_front();
                if (got.motor_drive !== want.motor_drive)
                    report_mismatch("motor_drive", got.motor_drive, want.motor_drive);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", got.busy_res, want.busy_res);
                if (got.pulses_left !== want.pulses_left)
                    report_mismatch("pulses_left", got.pulses_left, want.pulses_left);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned row;
        int unsigned phase;
        int unsigned n;
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = '0;
        cfg_data            = '0;
        cmd_bus.valid       = 1'b0;
        cmd_bus.opcode      = vptg_pkg::OP_TICK;
        cmd_bus.pulse_count = '0;
        cmd_bus.on_time_ms  = '0;
        cmd_bus.gap_time_ms = '0;
        motor_state         = '0;
        cfg_enable          = 1'b0;
        cfg_default_ms      = vptg_pkg::RESET_DEFAULT_MS;
        throttle_on         = 1'b1;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (row = 0; row < DISABLED_ROWS; row++)
            send_cmd(stim_rows[row].cmd, stim_rows[row].typed, stim_rows[row].want);
        wait_idle();
        write_reg(vptg_pkg::REG_ENABLE, 10'd1);
        for (row = DISABLED_ROWS; row < STIM_ROWS; row++)
            send_cmd(stim_rows[row].cmd, stim_rows[row].typed, stim_rows[row].want);

        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            write_reg(vptg_pkg::REG_ENABLE, {9'd0, phase_enable[phase]});
            write_reg(vptg_pkg::REG_DEFAULT_MS, (phase == PHASES - 1) ? 10'($urandom)
                                                                      : phase_default[phase]);
            throttle_on = (phase != 4);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(49) == 0) wait_idle();
                send_cmd(random_cmd(), 1'b0, IDLE_RESULT);
            end
        end
        wait_idle();

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
src/vptg_pkg.sv
src/vptg_cmd_if.sv
src/vptg_res_if.sv
src/vptg_step.sv
src/vibration_pulse_train_generator_top.sv
tb/sv/vibration_pulse_train_generator_top_tb.sv
